FILE: sv/assert_macros.svh
// Assertion macros shared by the in-order release block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define DIOR_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition must never be seen at a rising edge outside reset.
`define DIOR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

FILE: sv/dior_pkg.sv
// Shared types, constants and helpers for the in-order release block.
`default_nettype none

package dior_pkg;

	localparam int VAL_W          = 7;
	localparam int MAX_VALUES_DEF = 64;
	localparam int QUEUE_DEPTH    = 2;
	localparam int RESET_COUNT    = 64;

	// Classified arrival passed from front to back.
	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             rejected;
	} item_t;

	// Register write seen by both halves, count already clamped.
	typedef struct packed {
		logic             wr;
		logic [VAL_W-1:0] count;
	} cfg_t;

	function automatic logic [VAL_W-1:0] clamp_count(
		input logic [VAL_W-1:0] v,
		input logic [VAL_W-1:0] max_v
	);
		logic [VAL_W-1:0] r;
		if (v == '0) begin
			r = VAL_W'(1);
		end else if (v > max_v) begin
			r = max_v;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: sv/dior_front.sv
// Front end: holds the count register and seen map, classifies arrivals.
`default_nettype none

module dior_front #(
	parameter int MAX_VALUES = dior_pkg::MAX_VALUES_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [dior_pkg::VAL_W-1:0] arrival_value,
	input  wire logic                       cfg_wr_en,
	input  wire logic [dior_pkg::VAL_W-1:0] cfg_wr_data,
	input  wire logic                       queue_full,
	output dior_pkg::cfg_t                  cfg,
	output logic                            push,
	output dior_pkg::item_t                 push_item
);

	localparam int IDX_W = $clog2(MAX_VALUES);
	localparam logic [dior_pkg::VAL_W-1:0] MAX_V = dior_pkg::VAL_W'(MAX_VALUES);
	localparam logic [dior_pkg::VAL_W-1:0] RESET_V = dior_pkg::clamp_count(
		dior_pkg::VAL_W'(dior_pkg::RESET_COUNT), MAX_V);

	logic [dior_pkg::VAL_W-1:0] disk_count_q;
	logic [MAX_VALUES-1:0]      seen_q;
	logic [dior_pkg::VAL_W-1:0] vm1;
	logic [IDX_W-1:0]           idx;
	logic                       in_range;
	logic                       dup;

	assign vm1      = arrival_value - dior_pkg::VAL_W'(1);
	assign idx      = vm1[IDX_W-1:0];
	assign in_range = (arrival_value != '0) && (arrival_value <= disk_count_q);
	assign dup      = seen_q[idx];

	assign cfg.wr    = cfg_wr_en;
	assign cfg.count = dior_pkg::clamp_count(cfg_wr_data, MAX_V);

	assign push               = start && !queue_full;
	assign push_item.value    = arrival_value;
	assign push_item.rejected = !in_range || dup;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_count_q <= RESET_V;
			seen_q       <= '0;
		end else if (cfg_wr_en) begin
			// restart: new count, forget every arrival
			disk_count_q <= cfg.count;
			seen_q       <= '0;
		end else if (push && !push_item.rejected) begin
			seen_q[idx] <= 1'b1;
		end
	end

	`include "assert_macros.svh"

	`DIOR_ASSERT(a_front_reject_out_of_range, clk, arst_n,
		(push && ((arrival_value == '0) || (arrival_value > disk_count_q))) |-> push_item.rejected,
		"out-of-range arrival not rejected")

endmodule

`default_nettype wire

FILE: sv/dior_queue.sv
// Short queue of classified arrivals between front and back.
`default_nettype none

module dior_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire dior_pkg::item_t push_item,
	input  wire logic            pop,
	output dior_pkg::item_t      pop_item,
	output logic                 full,
	output logic                 empty
);

	localparam int DEPTH = dior_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	dior_pkg::item_t  entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	`include "assert_macros.svh"

	`DIOR_ASSERT_NEVER(a_queue_overflow, clk, arst_n, push && full && !pop,
		"push into full queue")
	`DIOR_ASSERT_NEVER(a_queue_underflow, clk, arst_n, pop && empty,
		"pop from empty queue")

endmodule

`default_nettype wire

FILE: sv/dior_back.sv
// Back end: holds the held map and next expected value, releases runs.
`default_nettype none

module dior_back #(
	parameter int MAX_VALUES = dior_pkg::MAX_VALUES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire dior_pkg::cfg_t              cfg,
	input  wire logic                        queue_empty,
	input  wire dior_pkg::item_t             pop_item,
	output logic                             pop,
	output logic                             result_strobe,
	output logic [dior_pkg::VAL_W-1:0]       released_value,
	output logic                             nothing_placed,
	output logic                             last_of_run,
	output logic                             input_rejected
);

	localparam int IDX_W = $clog2(MAX_VALUES);
	localparam logic [dior_pkg::VAL_W-1:0] MAX_V = dior_pkg::VAL_W'(MAX_VALUES);
	localparam logic [dior_pkg::VAL_W-1:0] RESET_V = dior_pkg::clamp_count(
		dior_pkg::VAL_W'(dior_pkg::RESET_COUNT), MAX_V);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic                       state_q;
	logic [MAX_VALUES-1:0]      held_q;
	logic [dior_pkg::VAL_W-1:0] next_q;

	logic                       strobe_q;
	logic [dior_pkg::VAL_W-1:0] value_q;
	logic                       none_q;
	logic                       last_q;
	logic                       rej_q;

	logic [dior_pkg::VAL_W-1:0] nm1;
	logic [dior_pkg::VAL_W-1:0] nm2;
	logic [dior_pkg::VAL_W-1:0] vm1;
	logic [IDX_W-1:0]           next_idx;
	logic [IDX_W-1:0]           below_idx;
	logic [IDX_W-1:0]           item_idx;
	logic                       run_ends;
	logic                       hit;

	assign nm1       = next_q - dior_pkg::VAL_W'(1);
	assign nm2       = next_q - dior_pkg::VAL_W'(2);
	assign vm1       = pop_item.value - dior_pkg::VAL_W'(1);
	assign next_idx  = nm1[IDX_W-1:0];
	assign below_idx = nm2[IDX_W-1:0];
	assign item_idx  = vm1[IDX_W-1:0];
	// the run stops once the value below the current one is not held
	assign run_ends  = (next_q == dior_pkg::VAL_W'(1)) || !held_q[below_idx];
	assign hit       = (pop_item.value == next_q);

	assign pop = (state_q == ST_IDLE) && !queue_empty && !cfg.wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			held_q   <= '0;
			next_q   <= RESET_V;
			strobe_q <= 1'b0;
			value_q  <= '0;
			none_q   <= 1'b0;
			last_q   <= 1'b0;
			rej_q    <= 1'b0;
		end else if (cfg.wr) begin
			state_q  <= ST_IDLE;
			held_q   <= '0;
			next_q   <= cfg.count;
			strobe_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						strobe_q <= 1'b1;
						if (pop_item.rejected) begin
							value_q <= '0;
							none_q  <= 1'b1;
							last_q  <= 1'b1;
							rej_q   <= 1'b1;
						end else if (hit) begin
							// arrival is the expected value: release it straight away
							value_q <= next_q;
							none_q  <= 1'b0;
							last_q  <= run_ends;
							rej_q   <= 1'b0;
							next_q  <= nm1;
							if (!run_ends) begin
								state_q <= ST_RUN;
							end
						end else begin
							held_q[item_idx] <= 1'b1;
							value_q <= '0;
							none_q  <= 1'b1;
							last_q  <= 1'b1;
							rej_q   <= 1'b0;
						end
					end else begin
						strobe_q <= 1'b0;
					end
				end
				ST_RUN: begin
					strobe_q         <= 1'b1;
					value_q          <= next_q;
					none_q           <= 1'b0;
					last_q           <= run_ends;
					rej_q            <= 1'b0;
					held_q[next_idx] <= 1'b0;
					next_q           <= nm1;
					if (run_ends) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					strobe_q <= 1'b0;
					state_q  <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_strobe  = strobe_q;
	assign released_value = value_q;
	assign nothing_placed = none_q;
	assign last_of_run    = last_q;
	assign input_rejected = rej_q;

	`include "assert_macros.svh"

	`DIOR_ASSERT(a_back_none_is_last, clk, arst_n,
		(result_strobe && nothing_placed) |-> (last_of_run && (released_value == '0)),
		"nothing-placed result must close the run with value zero")
	`DIOR_ASSERT(a_back_run_has_value, clk, arst_n,
		(state_q == ST_RUN) |-> ((next_q != '0) && held_q[next_idx]),
		"run continues without a held value")

endmodule

`default_nettype wire

FILE: sv/descending_in_order_release.sv
// Top level of the descending in-order release block.
//
//  channel   ports                                         handshake
//  --------  --------------------------------------------  --------------------------
//  arrival   start, busy, arrival_value                    taken when start && !busy
//  result    result_strobe, released_value, nothing_placed, one cycle per strobe
//            last_of_run, input_rejected
//  config    cfg_wr_en, cfg_wr_data (disk_count)           taken when cfg_wr_en
//
// The front classifies an arrival in the cycle it is taken and queues it; busy is high
// while the two-entry queue is full.
// The back forms one result per cycle while it has work; an arrival releasing k values gives k
// results (at least one). Each result appears on the ports in the cycle after it is formed.
// Reset clears both maps and sets disk_count and next expected value to min(64, MAX_VALUES);
// there is no clearing pass.
// Results cannot be held off by the receiver, so the back never stalls on the output.
`default_nettype none

module descending_in_order_release #(
	parameter int MAX_VALUES = dior_pkg::MAX_VALUES_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [dior_pkg::VAL_W-1:0] arrival_value,
	input  wire logic                       cfg_wr_en,
	input  wire logic [dior_pkg::VAL_W-1:0] cfg_wr_data,
	output logic                            result_strobe,
	output logic [dior_pkg::VAL_W-1:0]      released_value,
	output logic                            nothing_placed,
	output logic                            last_of_run,
	output logic                            input_rejected
);

	dior_pkg::cfg_t  cfg;
	dior_pkg::item_t push_item;
	dior_pkg::item_t pop_item;
	logic            push;
	logic            pop;
	logic            queue_full;
	logic            queue_empty;

	assign busy = queue_full;

	dior_front #(
		.MAX_VALUES(MAX_VALUES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.arrival_value(arrival_value),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.queue_full   (queue_full),
		.cfg          (cfg),
		.push         (push),
		.push_item    (push_item)
	);

	dior_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.pop_item (pop_item),
		.full     (queue_full),
		.empty    (queue_empty)
	);

	dior_back #(
		.MAX_VALUES(MAX_VALUES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.queue_empty   (queue_empty),
		.pop_item      (pop_item),
		.pop           (pop),
		.result_strobe (result_strobe),
		.released_value(released_value),
		.nothing_placed(nothing_placed),
		.last_of_run   (last_of_run),
		.input_rejected(input_rejected)
	);

endmodule

`default_nettype wire
